>>> hdl/tseps_pkg.sv
// Shared types and constants of the encrypted transport stream probe selector.
package tseps_pkg;

   // Header layout of one transport stream packet.
   localparam logic [7:0]  SYNC_VALUE    = 8'h47;
   localparam logic [12:0] PID_LOW       = 13'h0020;
   localparam logic [12:0] PID_HIGH      = 13'h1FFE;
   localparam int          POS_SYNC      = 0;
   localparam int          POS_PID_HIGH  = 1;
   localparam int          POS_PID_LOW   = 2;
   localparam int          POS_CONTROL   = 3;
   localparam int          POS_ADAPT_LEN = 4;

   // Adaptation field control codes.
   localparam logic [1:0] AFC_PAYLOAD_ONLY = 2'd1;
   localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'd3;

   // Start code prefix looked for at the head of every probe.
   localparam logic [7:0] START_ZERO = 8'h00;
   localparam logic [7:0] START_ONE  = 8'h01;

   // Entries in the result queue.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      EV_PROBE_BYTE      = 3'd0,
      EV_SYNC_LOST       = 3'd1,
      EV_PARITY_CONFLICT = 3'd2,
      EV_DONE            = 3'd3,
      EV_DONE_CLEAR      = 3'd4,
      EV_NO_ENCRYPTED    = 3'd5,
      EV_TOO_FEW         = 3'd6,
      EV_BAD_LENGTH      = 3'd7
   } event_type;

   // One queued result; a probe byte that closes the set carries the done
   // event with it and is sent as two words.
   typedef struct packed {
      event_type  event_res;
      logic [1:0] probe_number;
      logic [3:0] byte_number;
      logic [7:0] payload_byte;
      logic       done_follows;
      logic       done_clear;
   } rsp_entry_type;

   typedef struct packed {
      logic          push;
      rsp_entry_type entry;
   } push_type;

endpackage

>>> hdl/tseps_req_if.sv
// Input channel: stream bytes and the end of stream marker.
interface tseps_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] stream_byte;

   modport source (output valid, output cmd, output stream_byte, input ready);
   modport sink (input valid, input cmd, input stream_byte, output ready);
endinterface

>>> hdl/tseps_rsp_if.sv
// Result channel: probe bytes and status events.
interface tseps_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [1:0] probe_number;
   logic [3:0] byte_number;
   logic [7:0] payload_byte;
   logic       last;

   modport source (output valid, output event_res, output probe_number,
                   output byte_number, output payload_byte, output last, input ready);
   modport sink (input valid, input event_res, input probe_number,
                 input byte_number, input payload_byte, input last, output ready);
endinterface

>>> hdl/tseps_parser.sv
// Packet header parser, lock tracking and probe capture for one byte a cycle while bytes are accepted.
module tseps_parser #(
   parameter int PACKET_BYTES = 188,
   parameter int PROBE_BYTES  = 16,
   parameter int PROBE_COUNT  = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               cmd,
   input  logic [7:0]         stream_byte,
   output tseps_pkg::push_type push
);
   import tseps_pkg::*;

   localparam int PosWidth   = $clog2(PACKET_BYTES);
   localparam int AdaptLimit = PACKET_BYTES - 4 - 1 - PROBE_BYTES;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [12:0]         pid_ff, pid_in;
   logic [2:0]          flags_ff, flags_in;
   logic [1:0]          fc_ff, fc_in;
   logic [PosWidth-1:0] offset_ff, offset_in;
   logic                qualifies_ff, qualifies_in;
   logic [12:0]         locked_pid_ff, locked_pid_in;
   logic                pid_locked_ff, pid_locked_in;
   logic                locked_parity_ff, locked_parity_in;
   logic                parity_locked_ff, parity_locked_in;
   logic [1:0]          probes_ff, probes_in;
   logic                encrypted_ff, encrypted_in;
   logic                start_match_ff, start_match_in;
   logic                stopped_ff, stopped_in;

   logic [PosWidth:0]   pos_inc;
   logic [PosWidth:0]   window_end;
   logic [PosWidth-1:0] idx;
   logic                complete;
   logic                in_window;
   logic                end_of_probe;
   logic                start_match_next;
   logic [2:0]          j_flags;
   logic                pid_in_range;
   logic                j_candidate;
   logic                j_conflict;
   logic                judge_fire;

   assign pos_inc      = {1'b0, pos_ff} + (PosWidth+1)'(1);
   assign window_end   = {1'b0, offset_ff} + (PosWidth+1)'(PROBE_BYTES);
   assign idx          = pos_ff - offset_ff;
   assign complete     = probes_ff >= 2'(PROBE_COUNT);
   assign in_window    = qualifies_ff && (pos_ff >= offset_ff) && ({1'b0, pos_ff} < window_end);
   assign end_of_probe = idx == PosWidth'(PROBE_BYTES - 1);

   assign start_match_next = start_match_ff &&
      !((idx == PosWidth'(0) && stream_byte != START_ZERO) ||
        (idx == PosWidth'(1) && stream_byte != START_ZERO) ||
        (idx == PosWidth'(2) && stream_byte != START_ONE));

   // At the control byte the scrambling bits come straight from the byte.
   assign j_flags      = (pos_ff == PosWidth'(POS_CONTROL)) ?
                         {flags_ff[2], stream_byte[7:6]} : flags_ff;
   assign pid_in_range = (pid_ff >= PID_LOW) && (pid_ff <= PID_HIGH);
   assign j_candidate  = j_flags[1] && j_flags[2] && pid_in_range &&
                         !(pid_locked_ff && locked_pid_ff != pid_ff);
   assign j_conflict   = j_candidate && parity_locked_ff && (locked_parity_ff != j_flags[0]);

   always_comb begin
      pos_in           = pos_ff;
      pid_in           = pid_ff;
      flags_in         = flags_ff;
      fc_in            = fc_ff;
      offset_in        = offset_ff;
      qualifies_in     = qualifies_ff;
      locked_pid_in    = locked_pid_ff;
      pid_locked_in    = pid_locked_ff;
      locked_parity_in = locked_parity_ff;
      parity_locked_in = parity_locked_ff;
      probes_in        = probes_ff;
      encrypted_in     = encrypted_ff;
      start_match_in   = start_match_ff;
      stopped_in       = stopped_ff;
      judge_fire       = 1'b0;
      push             = '0;
      push.entry.event_res = EV_PROBE_BYTE;

      if (accept && !stopped_ff) begin
         if (cmd) begin
            stopped_in = 1'b1;
            if (pos_ff != '0) begin
               push.push = 1'b1;
               push.entry.event_res = EV_BAD_LENGTH;
            end else if (!complete) begin
               push.push = 1'b1;
               push.entry.event_res = encrypted_ff ? EV_TOO_FEW : EV_NO_ENCRYPTED;
            end
         end else begin
            pos_in = (pos_inc >= (PosWidth+1)'(PACKET_BYTES)) ? '0 : pos_inc[PosWidth-1:0];
            if (!complete) begin
               if (pos_ff == PosWidth'(POS_SYNC)) begin
                  if (stream_byte != SYNC_VALUE) begin
                     stopped_in = 1'b1;
                     push.push  = 1'b1;
                     push.entry.event_res = EV_SYNC_LOST;
                  end else begin
                     qualifies_in = 1'b0;
                  end
               end else if (pos_ff == PosWidth'(POS_PID_HIGH)) begin
                  flags_in[2] = stream_byte[6];
                  pid_in      = {stream_byte[4:0], pid_ff[7:0]};
               end else if (pos_ff == PosWidth'(POS_PID_LOW)) begin
                  pid_in = {pid_ff[12:8], stream_byte};
               end else if (pos_ff == PosWidth'(POS_CONTROL)) begin
                  flags_in[1:0] = stream_byte[7:6];
                  fc_in         = stream_byte[5:4];
                  if (stream_byte[5:4] == AFC_PAYLOAD_ONLY) begin
                     offset_in  = PosWidth'(4);
                     judge_fire = 1'b1;
                  end
               end else if (pos_ff == PosWidth'(POS_ADAPT_LEN) && fc_ff == AFC_ADAPT_PAYLOAD) begin
                  if ({1'b0, stream_byte} < 9'(AdaptLimit)) begin
                     offset_in  = PosWidth'(stream_byte + 8'd5);
                     judge_fire = 1'b1;
                  end
               end else if (in_window) begin
                  start_match_in = start_match_next;
                  push.push = 1'b1;
                  push.entry.probe_number = probes_ff;
                  push.entry.byte_number  = idx[3:0];
                  push.entry.payload_byte = stream_byte;
                  if (end_of_probe) begin
                     qualifies_in = 1'b0;
                     probes_in    = probes_ff + 2'd1;
                     if (probes_ff + 2'd1 >= 2'(PROBE_COUNT)) begin
                        push.entry.done_follows = 1'b1;
                        push.entry.done_clear   = start_match_next;
                     end
                  end
               end
            end
         end
      end

      if (judge_fire) begin
         if (j_flags[1]) begin
            encrypted_in = 1'b1;
         end
         if (j_candidate) begin
            locked_pid_in = pid_ff;
            pid_locked_in = 1'b1;
            if (j_conflict) begin
               stopped_in = 1'b1;
               push.push  = 1'b1;
               push.entry.event_res = EV_PARITY_CONFLICT;
            end else begin
               locked_parity_in = j_flags[0];
               parity_locked_in = 1'b1;
               qualifies_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         pid_ff           <= '0;
         flags_ff         <= '0;
         fc_ff            <= '0;
         offset_ff        <= '0;
         qualifies_ff     <= 1'b0;
         locked_pid_ff    <= '0;
         pid_locked_ff    <= 1'b0;
         locked_parity_ff <= 1'b0;
         parity_locked_ff <= 1'b0;
         probes_ff        <= '0;
         encrypted_ff     <= 1'b0;
         start_match_ff   <= 1'b1;
         stopped_ff       <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         pid_ff           <= pid_in;
         flags_ff         <= flags_in;
         fc_ff            <= fc_in;
         offset_ff        <= offset_in;
         qualifies_ff     <= qualifies_in;
         locked_pid_ff    <= locked_pid_in;
         pid_locked_ff    <= pid_locked_in;
         locked_parity_ff <= locked_parity_in;
         parity_locked_ff <= parity_locked_in;
         probes_ff        <= probes_in;
         encrypted_ff     <= encrypted_in;
         start_match_ff   <= start_match_in;
         stopped_ff       <= stopped_in;
      end
   end

`ifndef SYNTH
   // Nothing may leave the parser once it has stopped.
   a_no_push_when_stopped: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !push.push) else $error("result pushed after stop");

   a_probe_count_bound: assert property (@(posedge clock) disable iff (reset)
      probes_ff <= 2'(PROBE_COUNT)) else $error("probe count overrun");

   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      pid_locked_ff |=> pid_locked_ff) else $error("PID lock dropped");

   a_qualify_needs_lock: assert property (@(posedge clock) disable iff (reset)
      qualifies_ff |-> (pid_locked_ff && parity_locked_ff))
      else $error("packet qualifies without lock");
`endif

endmodule

>>> hdl/tseps_rsp_queue.sv
// Two-entry result queue that splits a closing probe byte into two words.
module tseps_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  tseps_pkg::push_type push,
   output logic                ready,
   tseps_rsp_if.source         rsp_ch
);
   import tseps_pkg::*;

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);

   rsp_entry_type       entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   count_ff, count_in;
   logic                phase_ff, phase_in;

   rsp_entry_type head;
   logic          fire;
   logic          pop;

   assign head  = entry_ff[rd_ptr_ff];
   assign ready = count_ff < (PtrWidth+1)'(QUEUE_DEPTH);

   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.event_res    = phase_ff ? (head.done_clear ? EV_DONE_CLEAR : EV_DONE)
                                         : head.event_res;
   assign rsp_ch.probe_number = phase_ff ? 2'd0 : head.probe_number;
   assign rsp_ch.byte_number  = phase_ff ? 4'd0 : head.byte_number;
   assign rsp_ch.payload_byte = phase_ff ? 8'd0 : head.payload_byte;
   assign rsp_ch.last         = phase_ff || !head.done_follows;

   assign fire = rsp_ch.valid && rsp_ch.ready;
   assign pop  = fire && (phase_ff || !head.done_follows);

   always_comb begin
      wr_ptr_in = push.push ? PtrWidth'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PtrWidth'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (PtrWidth+1)'(push.push) - (PtrWidth+1)'(pop);
      phase_in  = fire ? !pop : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push |-> ready) else $error("push into full result queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrWidth+1)'(QUEUE_DEPTH)) else $error("queue count overrun");

   a_phase_on_split: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (count_ff != '0 && head.done_follows))
      else $error("second half sent without a split entry");
`endif

endmodule

>>> hdl/ts_encrypted_probe_selector.sv
// Top level of the encrypted transport stream probe selector.
//
//   channel   direction   word carries
//   req_ch    in          cmd (byte or end of stream), stream_byte
//   rsp_ch    out         event_res, probe_number, byte_number, payload_byte, last
//
// One input word is taken every clock cycle while the queue is not full; its
// header parsing, lock tracking and probe capture finish in that cycle, and
// its results enter a two-entry queue that drives the result port from registers.
// A probe byte that completes the set leaves as two result words (the byte,
// then the done event) from a single queue entry.
// req_ch.ready is low only while the queue is full, so a stall on the result
// side holds the input back after two entries; there is no combinational
// path from rsp_ch.ready to req_ch.ready.
// Synchronous reset clears all control state; the block is ready at once.
module ts_encrypted_probe_selector #(
   parameter int PACKET_BYTES = 188,
   parameter int PROBE_BYTES  = 16,
   parameter int PROBE_COUNT  = 3
) (
   input logic         clock,
   input logic         reset,
   tseps_req_if.sink   req_ch,
   tseps_rsp_if.source rsp_ch
);
   import tseps_pkg::*;

   push_type push;
   logic     queue_ready;
   logic     accept;

   // A stream word is taken whenever the queue can hold its results.
   assign req_ch.ready = queue_ready;
   assign accept       = req_ch.valid && queue_ready;

   tseps_parser #(
      .PACKET_BYTES (PACKET_BYTES),
      .PROBE_BYTES  (PROBE_BYTES),
      .PROBE_COUNT  (PROBE_COUNT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_ch.cmd),
      .stream_byte (req_ch.stream_byte),
      .push        (push)
   );

   // The queue decouples the two sides and expands the closing probe byte.
   tseps_rsp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .ready  (queue_ready),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTH
   // A result is pushed into the queue only for an accepted word.
   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      push.push |-> accept) else $error("result pushed without an accepted word");

   // The last flag is clear only on a probe byte that carries the done event.
   a_last_split: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last) |-> (rsp_ch.event_res == EV_PROBE_BYTE))
      else $error("non-final word is not a probe byte");

   // The word that follows a non-final word is the done event.
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=>
      (rsp_ch.valid && rsp_ch.last &&
       (rsp_ch.event_res == EV_DONE || rsp_ch.event_res == EV_DONE_CLEAR)))
      else $error("done event missing after closing probe byte");
`endif

endmodule
